// ===== sv/rdim_pkg.sv =====
// Shared constants and types for the row dedup index mapper.
package rdim_pkg;

    localparam int MAX_ROWS = 128;
    localparam int CHANNELS = 4;
    localparam int IN_CH    = 4;
    localparam int KEY_CH   = (CHANNELS < IN_CH) ? CHANNELS : IN_CH;
    localparam int KEY_W    = 8 * KEY_CH;
    localparam int IDX_W    = 7;
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);
    localparam int GRP      = 8;
    localparam int NGRP     = (MAX_ROWS + GRP - 1) / GRP;

    localparam logic [IDX_W-1:0] DUP_MAX = 7'd127;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] origin;
    } t_entry;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] origin;
    } t_hit;

endpackage

// ===== sv/rdim_cell.sv =====
// One table cell: holds a stored row, shifts it on insert, compares it with the query.
module rdim_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic                          i_active,
    input  rdim_pkg::t_entry              i_prev,
    input  logic [rdim_pkg::KEY_W-1:0]    i_query,
    output rdim_pkg::t_entry              o_entry,
    output rdim_pkg::t_hit                o_hit
);
    import rdim_pkg::*;

    t_entry r_entry;
    logic   r_hit;
    logic   n_hit;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_prev;
        end
    end

    assign n_hit = i_active && (r_entry.key == i_query);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_entry      = r_entry;
    assign o_hit.hit    = r_hit;
    assign o_hit.idx    = r_hit ? r_entry.idx    : '0;
    assign o_hit.origin = r_hit ? r_entry.origin : '0;

endmodule

// ===== sv/rdim_or_tree.sv =====
// Two-stage registered OR reduction of the cell hit words.
module rdim_or_tree (
    input  logic                  i_clk,
    input  rdim_pkg::t_hit        i_hits [rdim_pkg::MAX_ROWS],
    output rdim_pkg::t_hit        o_hit
);
    import rdim_pkg::*;

    t_hit r_grp [NGRP];
    t_hit n_grp [NGRP];
    t_hit r_all;
    t_hit n_all;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < MAX_ROWS) begin
                    n_grp[g] = n_grp[g] | i_hits[g * GRP + k];
                end
            end
        end
    end

    always_comb begin
        n_all = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_all = n_all | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_all <= n_all;
    end

    assign o_hit = r_all;

endmodule

// ===== sv/row_dedup_index_mapper_unit.sv =====
// Row dedup index mapper top level: cell chain, hit reduction, counters and output word.
//
// Each input word is one matrix row of four channel pattern numbers. The row is
// compared in parallel with every distinct row stored in the cell chain; a match
// returns that entry's index and first row and bumps the saturating duplicate
// count, otherwise the row is shifted into the chain as a new entry. Rows past
// 128 in a run report overflow and leave the state alone. start_run clears the
// run before its row is handled. After an accept the word steps through S_CMP
// (compare in the cells), S_RED1 and S_RED2 (the registered OR tree) and S_UPD
// (update), then returns to idle; the next row is taken only in idle. The output
// register holds a finished word while the next row is accepted and worked on;
// only the update step waits if that register is still full.
module row_dedup_index_mapper_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_start_run,
    input  logic [7:0]                   i_pattern_ch0,
    input  logic [7:0]                   i_pattern_ch1,
    input  logic [7:0]                   i_pattern_ch2,
    input  logic [7:0]                   i_pattern_ch3,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rdim_pkg::IDX_W-1:0]   o_row_number,
    output logic [rdim_pkg::IDX_W-1:0]   o_unique_index,
    output logic                         o_is_new,
    output logic [rdim_pkg::IDX_W-1:0]   o_first_row,
    output logic [rdim_pkg::IDX_W-1:0]   o_dup_total,
    output logic                         o_overflow
);
    import rdim_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_RED1 = 5'b00100,
        S_RED2 = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_row_cnt, n_row_cnt;
    logic [CNT_W-1:0] r_entry_cnt, n_entry_cnt;
    logic [IDX_W-1:0] r_dup_cnt, n_dup_cnt;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_row_number, r_unique_index, r_first_row, r_dup_total;
    logic             r_is_new, r_overflow;

    logic [4*8-1:0]   w_key_all;
    logic             w_in_acc;
    logic             w_out_free;
    logic             w_upd;
    logic             w_over;
    logic             w_shift;
    t_entry           w_new;
    t_entry           w_chain  [MAX_ROWS+1];
    t_hit             w_hits   [MAX_ROWS];
    logic [MAX_ROWS-1:0] w_hit_vec;
    logic [MAX_ROWS-1:0] w_active;
    t_hit             w_found;

    assign w_key_all  = {i_pattern_ch3, i_pattern_ch2, i_pattern_ch1, i_pattern_ch0};
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_upd      = (r_state == S_UPD) && w_out_free;
    assign w_over     = (r_row_cnt >= CNT_W'(MAX_ROWS));
    assign w_shift    = w_upd && !w_over && !w_found.hit;

    assign w_new.key    = r_key;
    assign w_new.idx    = r_entry_cnt[IDX_W-1:0];
    assign w_new.origin = r_row_cnt[IDX_W-1:0];
    assign w_chain[0]   = w_new;

    for (genvar p = 0; p < MAX_ROWS; p++) begin : g_cell
        assign w_active[p]  = (CNT_W'(p) < r_entry_cnt);
        assign w_hit_vec[p] = w_hits[p].hit;
        rdim_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_shift),
            .i_active (w_active[p]),
            .i_prev   (w_chain[p]),
            .i_query  (r_key),
            .o_entry  (w_chain[p+1]),
            .o_hit    (w_hits[p])
        );
    end

    rdim_or_tree u_tree (
        .i_clk  (i_clk),
        .i_hits (w_hits),
        .o_hit  (w_found)
    );

    always_comb begin
        n_state     = r_state;
        n_row_cnt   = r_row_cnt;
        n_entry_cnt = r_entry_cnt;
        n_dup_cnt   = r_dup_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CMP;
                    if (i_start_run) begin
                        n_row_cnt   = '0;
                        n_entry_cnt = '0;
                        n_dup_cnt   = '0;
                    end
                end
            end
            S_CMP:  n_state = S_RED1;
            S_RED1: n_state = S_RED2;
            S_RED2: n_state = S_UPD;
            S_UPD: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (!w_over) begin
                        n_row_cnt = r_row_cnt + 1'b1;
                        if (w_found.hit) begin
                            if (r_dup_cnt < DUP_MAX) begin
                                n_dup_cnt = r_dup_cnt + 1'b1;
                            end
                        end else begin
                            n_entry_cnt = r_entry_cnt + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_cnt   <= '0;
            r_entry_cnt <= '0;
            r_dup_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_cnt   <= n_row_cnt;
            r_entry_cnt <= n_entry_cnt;
            r_dup_cnt   <= n_dup_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key <= w_key_all[KEY_W-1:0];
        end
        if (w_upd) begin
            if (w_over) begin
                r_row_number   <= '0;
                r_unique_index <= '0;
                r_is_new       <= 1'b0;
                r_first_row    <= '0;
                r_dup_total    <= '0;
                r_overflow     <= 1'b1;
            end else begin
                r_row_number   <= r_row_cnt[IDX_W-1:0];
                r_unique_index <= w_found.hit ? w_found.idx    : r_entry_cnt[IDX_W-1:0];
                r_is_new       <= !w_found.hit;
                r_first_row    <= w_found.hit ? w_found.origin : r_row_cnt[IDX_W-1:0];
                r_dup_total    <= n_dup_cnt;
                r_overflow     <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_number   = r_row_number;
    assign o_unique_index = r_unique_index;
    assign o_is_new       = r_is_new;
    assign o_first_row    = r_first_row;
    assign o_dup_total    = r_dup_total;
    assign o_overflow     = r_overflow;

    // stored rows are distinct, so at most one cell may hit
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit_vec))
        else $error("more than one cell matched the query");

    a_entries_le_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_cnt <= r_row_cnt)
        else $error("entry count ran past row count");

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_CMP))
        else $error("accepted word did not start a compare");

    a_ovf_not_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (!o_is_new && o_dup_total == '0))
        else $error("overflow word carries table fields");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for row_dedup_index_mapper_unit: random rows, stalls and a row-map predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdim_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_LEN    = 400;
    localparam int QUIET_LO    = 600;
    localparam int QUIET_HI    = 800;
    localparam int DRAIN_AT    = 900;

    typedef struct packed {
        logic            start_run;
        logic [3:0][7:0] ch;
        logic            drain;
    } t_row_word;

    typedef struct packed {
        logic [IDX_W-1:0] row_number;
        logic [IDX_W-1:0] unique_index;
        logic             is_new;
        logic [IDX_W-1:0] first_row;
        logic [IDX_W-1:0] dup_total;
        logic             overflow;
    } t_row_map;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_start_run = 1'b0;
    logic [7:0]       i_pattern_ch0 = '0;
    logic [7:0]       i_pattern_ch1 = '0;
    logic [7:0]       i_pattern_ch2 = '0;
    logic [7:0]       i_pattern_ch3 = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [IDX_W-1:0] o_row_number;
    logic [IDX_W-1:0] o_unique_index;
    logic             o_is_new;
    logic [IDX_W-1:0] o_first_row;
    logic [IDX_W-1:0] o_dup_total;
    logic             o_overflow;

    row_dedup_index_mapper_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_run    (i_start_run),
        .i_pattern_ch0  (i_pattern_ch0),
        .i_pattern_ch1  (i_pattern_ch1),
        .i_pattern_ch2  (i_pattern_ch2),
        .i_pattern_ch3  (i_pattern_ch3),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_row_number   (o_row_number),
        .o_unique_index (o_unique_index),
        .o_is_new       (o_is_new),
        .o_first_row    (o_first_row),
        .o_dup_total    (o_dup_total),
        .o_overflow     (o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_row_word  pending_rows[$];
    t_row_map   expected_maps[$];
    int         rows_taken = 0;
    int         n_err = 0;
    bit         in_taken = 1'b0;

    // predictor state
    logic [31:0]      seen_key[MAX_ROWS];
    logic [IDX_W-1:0] seen_origin[MAX_ROWS];
    int               n_entries = 0;
    int               run_row = 0;
    logic [IDX_W-1:0] dup_cnt = '0;

    function automatic t_row_map map_row(input t_row_word w);
        t_row_map    r;
        logic [31:0] key;
        int          hit;
        r = '0;
        if (w.start_run) begin
            n_entries = 0;
            run_row   = 0;
            dup_cnt   = '0;
        end
        if (run_row >= MAX_ROWS) begin
            r.overflow = 1'b1;
            return r;
        end
        key = '0;
        for (int c = 0; c < KEY_CH; c++) key[8*c +: 8] = w.ch[c];
        hit = -1;
        for (int i = 0; i < n_entries; i++)
            if (hit < 0 && seen_key[i] == key) hit = i;
        r.row_number = run_row[IDX_W-1:0];
        if (hit >= 0) begin
            r.unique_index = hit[IDX_W-1:0];
            r.first_row    = seen_origin[hit];
            if (dup_cnt < DUP_MAX) dup_cnt++;
        end else if (n_entries < MAX_ROWS) begin
            seen_key[n_entries]    = key;
            seen_origin[n_entries] = run_row[IDX_W-1:0];
            r.unique_index = n_entries[IDX_W-1:0];
            r.first_row    = run_row[IDX_W-1:0];
            r.is_new       = 1'b1;
            n_entries++;
        end
        r.dup_total = dup_cnt;
        run_row++;
        return r;
    endfunction

    function automatic bit idle_now();
        return (rows_taken < QUIET_LO || rows_taken >= QUIET_HI) && $urandom_range(0, 99) < 16;
    endfunction

    task automatic add_row(input bit start, input logic [31:0] content);
        t_row_word w;
        w.start_run = start;
        w.ch        = content;
        w.drain     = (pending_rows.size() == DRAIN_AT);
        pending_rows.push_back(w);
    endtask

    task automatic build_rows();
        logic [31:0] pool[$];
        logic [31:0] k;
        int          kind;
        int          len;
        int          npool;
        int          pick;
        // one-row runs, extremes, near misses in each channel, restart
        add_row(1'b1, 32'h0000_0000);
        add_row(1'b1, 32'hFFFF_FFFF);
        add_row(1'b0, 32'h0000_0000);
        add_row(1'b0, 32'hFFFF_FFFF);
        add_row(1'b0, 32'h0000_0000);
        add_row(1'b0, 32'h0403_0201);
        add_row(1'b0, 32'h0503_0201);
        add_row(1'b0, 32'h0000_0080);
        add_row(1'b0, 32'h0000_8000);
        add_row(1'b0, 32'h0080_0000);
        add_row(1'b0, 32'h8000_0000);
        add_row(1'b0, 32'h0403_0201);
        add_row(1'b1, 32'h0403_0201);
        add_row(1'b0, 32'h0403_0201);
        add_row(1'b0, 32'h0000_0080);
        // one content for a whole run: duplicate count tops out, then overflow
        k = $urandom;
        for (int i = 0; i < 132; i++) add_row(i == 0, k);
        while (pending_rows.size() < 1060) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                // stray rows that extend the current run
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) add_row(1'b0, $urandom);
            end else begin
                if (kind < 75) begin
                    len   = $urandom_range(1, 40);
                    npool = $urandom_range(1, 12);
                end else if (kind < 92) begin
                    len   = $urandom_range(120, 140);
                    npool = $urandom_range(20, 100);
                end else begin
                    len   = $urandom_range(128, 136);
                    npool = 1;
                end
                pool.delete();
                for (int i = 0; i < npool; i++) pool.push_back($urandom);
                for (int i = 0; i < len; i++) begin
                    pick = (kind >= 92) ? 0 : $urandom_range(0, 99);
                    k = pool[$urandom_range(0, npool - 1)];
                    if (pick >= 80)
                        k = $urandom;
                    else if (pick >= 65)
                        k[8*$urandom_range(0, 3) +: 8] = 8'($urandom);
                    add_row(i == 0, k);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        t_row_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // word still offered
        end else if (pending_rows.size() == 0 || idle_now() ||
                     (pending_rows[0].drain && expected_maps.size() != 0)) begin
            i_in_valid <= 1'b0;
        end else begin
            w = pending_rows.pop_front();
            i_in_valid    <= 1'b1;
            i_start_run   <= w.start_run;
            i_pattern_ch0 <= w.ch[0];
            i_pattern_ch1 <= w.ch[1];
            i_pattern_ch2 <= w.ch[2];
            i_pattern_ch3 <= w.ch[3];
        end
    end

    // receiver
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!hold_done && rows_taken >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_now();
        end
    end

    // accept, predict and compare
    always @(posedge i_clk) begin
        t_row_word w;
        t_row_map  e;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            w.start_run = i_start_run;
            w.ch        = {i_pattern_ch3, i_pattern_ch2, i_pattern_ch1, i_pattern_ch0};
            w.drain     = 1'b0;
            expected_maps.push_back(map_row(w));
            rows_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_maps.size() == 0) begin
                $error("result word with no row pending");
                n_err++;
            end else begin
                e = expected_maps.pop_front();
                check_field("row_number", e.row_number, o_row_number);
                check_field("unique_index", e.unique_index, o_unique_index);
                check_field("is_new", e.is_new, o_is_new);
                check_field("first_row", e.first_row, o_first_row);
                check_field("dup_total", e.dup_total, o_dup_total);
                check_field("overflow", e.overflow, o_overflow);
            end
        end
    end

    initial begin
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("FAIL row_dedup_index_mapper_unit");
        $finish;
    end

    initial begin
        int total;
        build_rows();
        total = pending_rows.size();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (rows_taken < total) @(posedge i_clk);
        while (expected_maps.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_maps.size() != 0) begin
            $error("%0d result words never arrived", expected_maps.size());
            n_err++;
        end
        if (n_err == 0) begin
            $display("PASS row_dedup_index_mapper_unit");
        end else begin
            $display("FAIL row_dedup_index_mapper_unit");
        end
        $finish;
    end
endmodule
